// ----- design/dssm_pkg.sv -----
// Package for the dual stack shared memory block.
// Holds operation, status and state codes and the result beat layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dssm_pkg;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned IN_TDATA_W = 32;
    localparam int unsigned OUT_PAD_W  = 2;
    localparam int unsigned OUT_TDATA_W =
        STATUS_W + 2 * (WORD_W + 1) + 2 * COUNT_W + OUT_PAD_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_ONE = 3'd0,
        OP_POP_ONE  = 3'd1,
        OP_PUSH_TWO = 3'd2,
        OP_POP_TWO  = 3'd3,
        OP_QUERY    = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL_ONE,
        S_FILL_TWO
    } state_t;

    typedef struct packed {
        status_t                   status;
        logic signed [WORD_W-1:0]  top_one_value;
        logic                      top_one_valid;
        logic signed [WORD_W-1:0]  top_two_value;
        logic                      top_two_valid;
        logic [COUNT_W-1:0]        count_one;
        logic [COUNT_W-1:0]        count_two;
    } result_t;

endpackage

`default_nettype wire

// ----- design/dual_stack_shared_memory.sv -----
// Two LIFO stacks in one shared word memory, stack one growing up, stack two down.
// Depends on dssm_pkg for codes and the result layout.
// A push, a query, a refused operation or a pop that empties its stack gives its result
// beat in the cycle after acceptance; a pop that exposes a lower word first reads the new
// top from the memory's single registered read port, then gives its beat from the fill state.
// Throughput: one item per cycle unless m_tready holds the output; reading pops stall input.
// Reset clears both counts, the pop state and the output valid flag; the word memory
// and the output data are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module dual_stack_shared_memory #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // push_value[31:0]
    input  wire logic [dssm_pkg::IN_TDATA_W-1:0]       s_tdata,
    // op[2:0]
    input  wire logic [dssm_pkg::OP_W-1:0]             s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // status[1:0], top_one_value[33:2], top_one_valid[34], top_two_value[66:35],
    // top_two_valid[67], count_one[72:68], count_two[77:73], zero pad[79:78]
    output logic [dssm_pkg::OUT_TDATA_W-1:0]           m_tdata
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    dssm_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     fill_one_reg, fill_one_next;
    logic [CW-1:0]     fill_two_reg, fill_two_next;
    logic signed [dssm_pkg::WORD_W-1:0] top_one_reg, top_one_next;
    logic signed [dssm_pkg::WORD_W-1:0] top_two_reg, top_two_next;
    logic              m_valid_reg, m_valid_next;
    dssm_pkg::result_t out_reg, result;

    logic [dssm_pkg::WORD_W-1:0] mem [DEPTH];
    logic [dssm_pkg::WORD_W-1:0] rd_data_reg;
    logic              mem_we, mem_re;
    logic [AW-1:0]     wr_addr, rd_addr;

    logic              load_out, room;
    dssm_pkg::status_t status;
    dssm_pkg::op_t     op;
    logic [CW:0]       fill_sum;
    logic [CW+4:0]     count_one_ext, count_two_ext;

    assign op       = dssm_pkg::op_t'(s_tuser);
    assign fill_sum = {1'b0, fill_one_reg} + {1'b0, fill_two_reg};
    assign room     = fill_sum < (CW + 1)'(DEPTH);

    always_comb
    begin
        state_next    = state_reg;
        fill_one_next = fill_one_reg;
        fill_two_next = fill_two_reg;
        top_one_next  = top_one_reg;
        top_two_next  = top_two_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        wr_addr       = fill_one_reg[AW-1:0];
        rd_addr       = fill_one_reg[AW-1:0] - AW'(2);
        load_out      = 1'b0;
        status        = dssm_pkg::ST_OK;
        s_tready      = 1'b0;
        unique case (state_reg)
            dssm_pkg::S_IDLE:
            begin
                s_tready = !m_valid_reg || m_tready;
                if (s_tvalid && s_tready)
                begin
                    case (op)
                        dssm_pkg::OP_PUSH_ONE:
                        begin
                            load_out = 1'b1;
                            if (room)
                            begin
                                mem_we        = 1'b1;
                                wr_addr       = fill_one_reg[AW-1:0];
                                fill_one_next = fill_one_reg + CW'(1);
                                top_one_next  = s_tdata;
                            end
                            else
                            begin
                                status = dssm_pkg::ST_OVERFLOW;
                            end
                        end
                        dssm_pkg::OP_PUSH_TWO:
                        begin
                            load_out = 1'b1;
                            if (room)
                            begin
                                mem_we        = 1'b1;
                                wr_addr       = AW'(DEPTH - 1) - fill_two_reg[AW-1:0];
                                fill_two_next = fill_two_reg + CW'(1);
                                top_two_next  = s_tdata;
                            end
                            else
                            begin
                                status = dssm_pkg::ST_OVERFLOW;
                            end
                        end
                        dssm_pkg::OP_POP_ONE:
                        begin
                            if (fill_one_reg == '0)
                            begin
                                status   = dssm_pkg::ST_UNDERFLOW;
                                load_out = 1'b1;
                            end
                            else
                            begin
                                fill_one_next = fill_one_reg - CW'(1);
                                if (fill_one_reg == CW'(1))
                                begin
                                    load_out = 1'b1;
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    rd_addr    = fill_one_reg[AW-1:0] - AW'(2);
                                    state_next = dssm_pkg::S_FILL_ONE;
                                end
                            end
                        end
                        dssm_pkg::OP_POP_TWO:
                        begin
                            if (fill_two_reg == '0)
                            begin
                                status   = dssm_pkg::ST_UNDERFLOW;
                                load_out = 1'b1;
                            end
                            else
                            begin
                                fill_two_next = fill_two_reg - CW'(1);
                                if (fill_two_reg == CW'(1))
                                begin
                                    load_out = 1'b1;
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    rd_addr    = AW'(DEPTH + 1) - fill_two_reg[AW-1:0];
                                    state_next = dssm_pkg::S_FILL_TWO;
                                end
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            dssm_pkg::S_FILL_ONE:
            begin
                top_one_next = rd_data_reg;
                load_out     = 1'b1;
                state_next   = dssm_pkg::S_IDLE;
            end
            dssm_pkg::S_FILL_TWO:
            begin
                top_two_next = rd_data_reg;
                load_out     = 1'b1;
                state_next   = dssm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dssm_pkg::S_IDLE;
            end
        endcase
    end

    assign count_one_ext = {5'b0, fill_one_next};
    assign count_two_ext = {5'b0, fill_two_next};

    always_comb
    begin
        result.status        = status;
        result.top_one_valid = (fill_one_next != '0);
        result.top_one_value = result.top_one_valid ? top_one_next : '0;
        result.top_two_valid = (fill_two_next != '0);
        result.top_two_value = result.top_two_valid ? top_two_next : '0;
        result.count_one     = count_one_ext[dssm_pkg::COUNT_W-1:0];
        result.count_two     = count_two_ext[dssm_pkg::COUNT_W-1:0];
    end

    always_comb
    begin
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dssm_pkg::S_IDLE;
            fill_one_reg <= '0;
            fill_two_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_one_reg <= fill_one_next;
            fill_two_reg <= fill_two_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_one_reg <= top_one_next;
        top_two_reg <= top_two_next;
        if (load_out)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= s_tdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{dssm_pkg::OUT_PAD_W{1'b0}},
                       out_reg.count_two, out_reg.count_one,
                       out_reg.top_two_valid, out_reg.top_two_value,
                       out_reg.top_one_valid, out_reg.top_one_value,
                       out_reg.status};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, fill_one_reg} + {1'b0, fill_two_reg}) <= (CW + 1)'(DEPTH))
        else $error("stack fills exceed the shared memory depth");

    a_fill_state_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != dssm_pkg::S_IDLE) |-> !m_valid_reg)
        else $error("output beat pending while a pop waits for its read");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("memory written and read in the same cycle");

    a_pop_reads_then_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_re) |=> (load_out && state_reg != dssm_pkg::S_IDLE))
        else $error("pop read did not produce a result beat next cycle");
`endif

endmodule

`default_nettype wire
